// File: rtl/core/batm_pkg.sv
// Package with shared constants, tables and types for the battery ADC filter.
`timescale 1ns / 1ps
package batm_pkg;

    localparam int SampleWidth       = 11;
    localparam int SampleFields      = 5;
    localparam int StoredEntries     = 81;
    localparam int DefNumSamples     = 5;
    localparam int DefTableEntries   = 81;
    localparam logic [10:0] FullThresholdReset = 11'd203;

    localparam logic [0:0] RegBoardVariant  = 1'b0;
    localparam logic [0:0] RegFullThreshold = 1'b1;

    localparam logic [0:0] ModeCurrent = 1'b0;
    localparam logic [0:0] ModeTherm   = 1'b1;

    typedef logic [SampleWidth-1:0] sample_t;

    // Front-end register contents handed to the result stage.
    typedef struct packed {
        logic    fail;
        logic    mode;
        sample_t mean;
    } mean_info_t;

    function automatic logic [9:0] key_lookup(input logic variant, input logic [6:0] idx);
        logic [9:0] k0 [0:80];
        logic [9:0] k1 [0:80];
        k0 = '{10'd75, 10'd78, 10'd82, 10'd84, 10'd87, 10'd89, 10'd92, 10'd95, 10'd99,
               10'd102, 10'd105, 10'd109, 10'd113, 10'd117, 10'd121, 10'd124, 10'd127,
               10'd135, 10'd139, 10'd143, 10'd147, 10'd153, 10'd158, 10'd163, 10'd169,
               10'd175, 10'd181, 10'd187, 10'd193, 10'd199, 10'd205, 10'd212, 10'd218,
               10'd227, 10'd233, 10'd240, 10'd249, 10'd258, 10'd267, 10'd276, 10'd285,
               10'd299, 10'd308, 10'd313, 10'd322, 10'd331, 10'd342, 10'd355, 10'd363,
               10'd373, 10'd383, 10'd394, 10'd407, 10'd417, 10'd427, 10'd437, 10'd450,
               10'd465, 10'd475, 10'd487, 10'd500, 10'd514, 10'd526, 10'd540, 10'd552,
               10'd565, 10'd577, 10'd589, 10'd603, 10'd614, 10'd628, 10'd639, 10'd664,
               10'd689, 10'd717, 10'd744, 10'd754, 10'd765, 10'd776, 10'd787, 10'd798};
        k1 = '{10'd63, 10'd66, 10'd67, 10'd71, 10'd73, 10'd75, 10'd79, 10'd81, 10'd83,
               10'd86, 10'd89, 10'd92, 10'd95, 10'd98, 10'd102, 10'd106, 10'd110,
               10'd114, 10'd118, 10'd122, 10'd126, 10'd130, 10'd134, 10'd139, 10'd144,
               10'd150, 10'd155, 10'd160, 10'd165, 10'd171, 10'd176, 10'd185, 10'd191,
               10'd198, 10'd205, 10'd211, 10'd218, 10'd225, 10'd232, 10'd240, 10'd248,
               10'd256, 10'd265, 10'd274, 10'd283, 10'd292, 10'd302, 10'd313, 10'd323,
               10'd334, 10'd344, 10'd354, 10'd365, 10'd375, 10'd386, 10'd396, 10'd410,
               10'd423, 10'd436, 10'd449, 10'd462, 10'd473, 10'd484, 10'd495, 10'd506,
               10'd517, 10'd530, 10'd543, 10'd557, 10'd570, 10'd582, 10'd596, 10'd610,
               10'd623, 10'd636, 10'd650, 10'd663, 10'd676, 10'd686, 10'd696, 10'd716};
        if (idx > 7'd80)
        begin
            key_lookup = 10'd0;
        end
        else if (variant)
        begin
            key_lookup = k1[idx];
        end
        else
        begin
            key_lookup = k0[idx];
        end
    endfunction

endpackage

// File: rtl/core/batm_mean.sv
// Trimmed-mean front end: min, max, sum and divide by the kept sample count.
`timescale 1ns / 1ps
module batm_mean
    import batm_pkg::*;
#(
    parameter int NUM_SAMPLES = DefNumSamples
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    mode,
    input  logic    conversion_failed,
    input  sample_t sample_a,
    input  sample_t sample_b,
    input  sample_t sample_c,
    input  sample_t sample_d,
    input  sample_t sample_e,
    output logic    vld,
    output mean_info_t info
);
    localparam int SumWidth = SampleWidth + $clog2(NUM_SAMPLES + 1);
    localparam int Div      = (NUM_SAMPLES > 2) ? NUM_SAMPLES - 2 : 1;
    localparam int RecipSh  = SumWidth + 2;
    localparam int Recip    = ((1 << RecipSh) + Div - 1) / Div;
    localparam int RecipW   = RecipSh + 1;

    sample_t             fields [SampleFields];
    logic [SumWidth-1:0] sum, trimmed;
    sample_t             hi, lo, mean;
    logic [SumWidth+RecipW-1:0] prod;
    logic                vld_reg;
    mean_info_t          info_reg, info_next;

    assign fields[0] = sample_a;
    assign fields[1] = sample_b;
    assign fields[2] = sample_c;
    assign fields[3] = sample_d;
    assign fields[4] = sample_e;

    always_comb
    begin
        sum = '0;
        hi  = '0;
        lo  = '1;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            sum = sum + SumWidth'(fields[i % SampleFields]);
            if (fields[i % SampleFields] > hi) hi = fields[i % SampleFields];
            if (fields[i % SampleFields] < lo) lo = fields[i % SampleFields];
        end
        trimmed = sum - SumWidth'(hi) - SumWidth'(lo);
        // Exact division by a constant through a rounded-up reciprocal.
        prod = SumWidth'(trimmed) * RecipW'(Recip);
        mean = SampleWidth'(prod >> RecipSh);
        info_next.fail = conversion_failed;
        info_next.mode = mode;
        info_next.mean = conversion_failed ? '0 : mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign vld  = vld_reg;
    assign info = info_reg;
endmodule

// File: rtl/core/batm_result.sv
// Result stage: threshold compare, thermistor table search and result register.
`timescale 1ns / 1ps
module batm_result
    import batm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DefTableEntries
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vld,
    input  mean_info_t info,
    input  logic       variant,
    input  sample_t    threshold,
    output logic       done,
    output logic       status,
    output sample_t    mean_value,
    output logic       charge_full,
    output logic signed [10:0] temperature
);
    localparam int N = (TABLE_ENTRIES < StoredEntries) ?
                       ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES) : StoredEntries;

    logic [6:0]  pick;
    logic signed [10:0] temp;
    logic        done_reg;
    logic        status_reg, full_reg;
    sample_t     mean_reg;
    logic signed [10:0] temp_reg;

    always_comb
    begin
        // Keys rise, so the matches form a prefix; count them in parallel.
        pick = '0;
        for (int i = 1; i < N; i++)
        begin
            if (SampleWidth'(key_lookup(variant, 7'(i))) <= info.mean) pick = 7'(i);
        end
        temp = 11'sd700 - 11'(signed'({4'd0, pick}) * 11'sd10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= info.fail;
        mean_reg   <= info.mean;
        full_reg   <= !info.fail && info.mode == ModeCurrent && info.mean < threshold;
        temp_reg   <= (!info.fail && info.mode == ModeTherm) ? temp : '0;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign mean_value  = mean_reg;
    assign charge_full = full_reg;
    assign temperature = temp_reg;
endmodule

// File: rtl/core/battery_adc_trimmed_mean_thermistor_top.sv
// Top level of the battery ADC trimmed-mean filter with thermistor lookup.
// The start transfer passes through the mean register and then the result register to the done strobe.
// Throughput: one item per cycle, set by the two register stages (mean, lookup).
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the strobes; board_variant resets to 0 and full_threshold to 203.
// busy is always low, since every stage moves on in every cycle.
`timescale 1ns / 1ps
module battery_adc_trimmed_mean_thermistor_top
    import batm_pkg::*;
#(
    parameter int NUM_SAMPLES   = DefNumSamples,
    parameter int TABLE_ENTRIES = DefTableEntries
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        mode,
    input  sample_t     sample_a,
    input  sample_t     sample_b,
    input  sample_t     sample_c,
    input  sample_t     sample_d,
    input  sample_t     sample_e,
    input  logic        conversion_failed,
    output logic        done,
    output logic        status,
    output sample_t     mean_value,
    output logic        charge_full,
    output logic signed [10:0] temperature
);
    logic       variant_reg;
    sample_t    threshold_reg;
    logic       vld;
    mean_info_t info;

    // Configuration registers, written directly from the write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= 1'b0;
            threshold_reg <= FullThresholdReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == RegBoardVariant) variant_reg <= cfg_data[0];
            if (cfg_index == RegFullThreshold) threshold_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    batm_mean #(.NUM_SAMPLES(NUM_SAMPLES)) u_mean (
        .clk(clk), .rst_n(rst_n), .start(start && !busy), .mode(mode),
        .conversion_failed(conversion_failed),
        .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c),
        .sample_d(sample_d), .sample_e(sample_e),
        .vld(vld), .info(info)
    );

    batm_result #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_result (
        .clk(clk), .rst_n(rst_n), .vld(vld), .info(info),
        .variant(variant_reg), .threshold(threshold_reg),
        .done(done), .status(status), .mean_value(mean_value),
        .charge_full(charge_full), .temperature(temperature)
    );
endmodule
